// ----- design/fpr_pkg.sv -----
// types and constants shared by the framed packet receiver
package fpr_pkg;

	localparam logic [7:0] SOF_BYTE = 8'h7E;
	localparam logic [7:0] EOT_BYTE = 8'h0D;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_ACCEPT  = 2'd1,
		KIND_BAD_SUM = 2'd2,
		KIND_BAD_END = 2'd3
	} kind_t;

	typedef enum logic [5:0] {
		PH_START = 6'b000001,
		PH_ID    = 6'b000010,
		PH_LEN   = 6'b000100,
		PH_DATA  = 6'b001000,
		PH_SUM   = 6'b010000,
		PH_END   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic       emit;
		kind_t      kind;
		logic [7:0] msg_id;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic [7:0] payload_length;
	} result_t;

endpackage

// ----- design/fpr_if.sv -----
// valid/ready channel interfaces for received bytes and parser results
interface fpr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpr_result_if;
	logic                valid;
	logic                ready;
	fpr_pkg::kind_t      kind;
	logic [7:0]          msg_id;
	logic [7:0]          payload_byte;
	logic [7:0]          byte_index;
	logic [7:0]          payload_length;

	modport source (output valid, output kind, output msg_id, output payload_byte,
		output byte_index, output payload_length, input ready);
	modport sink (input valid, input kind, input msg_id, input payload_byte,
		input byte_index, input payload_length, output ready);
endinterface

// ----- design/fpr_parser.sv -----
// frame parser state and per-byte next-state and result logic
module fpr_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data,
	output fpr_pkg::result_t    res
);

	fpr_pkg::phase_t phase_q, phase_d;
	logic [7:0] frame_id_q, frame_id_d;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] position_q, position_d;

	always_comb begin
		phase_d      = phase_q;
		frame_id_d   = frame_id_q;
		bytes_left_d = bytes_left_q;
		sum_d        = sum_q;
		position_d   = position_q;
		res          = '0;
		res.msg_id   = frame_id_q;
		res.kind     = fpr_pkg::KIND_DATA;
		case (phase_q)
			fpr_pkg::PH_START: begin
				if (data == fpr_pkg::SOF_BYTE) begin
					phase_d    = fpr_pkg::PH_ID;
					position_d = 8'd0;
					sum_d      = 8'd0;
				end
			end
			fpr_pkg::PH_ID: begin
				frame_id_d = data;
				phase_d    = fpr_pkg::PH_LEN;
			end
			fpr_pkg::PH_LEN: begin
				sum_d      = data;
				position_d = 8'd0;
				if (data > 8'd1) begin
					bytes_left_d = data - 8'd1;
					phase_d      = fpr_pkg::PH_DATA;
				end else begin
					bytes_left_d = 8'd0;
					phase_d      = fpr_pkg::PH_SUM;
				end
			end
			fpr_pkg::PH_DATA: begin
				res.emit           = 1'b1;
				res.kind           = fpr_pkg::KIND_DATA;
				res.payload_byte   = data;
				res.byte_index     = position_q;
				res.payload_length = position_q + bytes_left_q;
				sum_d              = sum_q + data;
				position_d         = position_q + 8'd1;
				bytes_left_d       = bytes_left_q - 8'd1;
				if (bytes_left_d == 8'd0) begin
					phase_d = fpr_pkg::PH_SUM;
				end
			end
			fpr_pkg::PH_SUM: begin
				if (sum_q == data) begin
					phase_d = fpr_pkg::PH_END;
				end else begin
					res.emit           = 1'b1;
					res.kind           = fpr_pkg::KIND_BAD_SUM;
					res.payload_length = position_q;
					phase_d            = fpr_pkg::PH_START;
				end
			end
			fpr_pkg::PH_END: begin
				res.emit           = 1'b1;
				res.kind           = (data == fpr_pkg::EOT_BYTE) ? fpr_pkg::KIND_ACCEPT
					: fpr_pkg::KIND_BAD_END;
				res.payload_length = position_q;
				phase_d            = fpr_pkg::PH_START;
			end
			default: begin
				phase_d = fpr_pkg::PH_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= fpr_pkg::PH_START;
			frame_id_q   <= 8'd0;
			bytes_left_q <= 8'd0;
			sum_q        <= 8'd0;
			position_q   <= 8'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			frame_id_q   <= frame_id_d;
			bytes_left_q <= bytes_left_d;
			sum_q        <= sum_d;
			position_q   <= position_d;
		end
	end

endmodule

// ----- design/framed_packet_receiver.sv -----
// framed packet receiver top level: input register, parser and result register
// Takes one received byte per cycle and reports payload bytes and frame
// status (accepted, bad checksum, bad end byte) on the result channel. A byte
// passes through an input register, the parser, and a result register, from
// which its result is presented. Throughput is one byte every cycle while no
// result waits on the sink; the parser keeps an 8-bit running checksum of the
// length and payload bytes. Bytes that produce no result send no transaction.
// While a result waits on the sink, the parser holds and the input register
// stalls, so the input side takes at most one more byte until it is taken.
module framed_packet_receiver (
	input  logic                clk,
	input  logic                arst_n,
	fpr_byte_if.sink            rx,
	fpr_result_if.source        res
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_valid_q;
	fpr_pkg::result_t out_q;
	fpr_pkg::result_t step_res;
	logic             advance;

	assign advance  = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	fpr_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data   (byte_s1),
		.res    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_res.emit;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.emit) begin
			out_q <= step_res;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.kind           = out_q.kind;
	assign res.msg_id         = out_q.msg_id;
	assign res.payload_byte   = out_q.payload_byte;
	assign res.byte_index     = out_q.byte_index;
	assign res.payload_length = out_q.payload_length;

endmodule
